// File: src/cpc_pkg.sv
package cpc_pkg;

	localparam int PIXEL_W = 8;
	localparam int COUNT_W = 18;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 4;
	localparam int REG_IDX_W = 2;

	localparam int WIDTH_REG_W = 10;
	localparam int HEIGHT_REG_W = 9;
	localparam int THRESH_REG_W = 8;

	localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = WIDTH_REG_W'(320);
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(200);
	localparam logic [THRESH_REG_W-1:0] THRESH_RESET = THRESH_REG_W'(128);

	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

	typedef struct packed {
		logic push;
		logic reload;
		logic left_wr;
		logic end_wr;
		logic left_flag;
		logic flag;
		logic [PIXEL_W-1:0] pixel;
	} cell_bus_t;

endpackage

// File: src/cpc_cell.sv
module cpc_cell #(
	parameter int COL_W = 9,
	parameter int INDEX = 0
) (
	input  logic                          clk,
	input  logic [COL_W-1:0]              col,
	input  cpc_pkg::cell_bus_t            bus,
	input  logic [cpc_pkg::PIXEL_W-1:0]   nxt_st_pix,
	input  logic                          nxt_st_flag,
	input  logic [cpc_pkg::PIXEL_W-1:0]   nxt_rd_pix,
	input  logic                          nxt_rd_flag,
	output logic [cpc_pkg::PIXEL_W-1:0]   st_pix,
	output logic                          st_flag,
	output logic [cpc_pkg::PIXEL_W-1:0]   rd_pix,
	output logic                          rd_flag
);

	localparam logic [COL_W:0] SELF = (COL_W+1)'(INDEX);
	localparam logic [COL_W:0] NEIGH = (COL_W+1)'(INDEX + 1);

	logic [cpc_pkg::PIXEL_W-1:0] st_pix_q;
	logic                        st_flag_q;
	logic [cpc_pkg::PIXEL_W-1:0] rd_pix_q;
	logic                        rd_flag_q;
	logic [COL_W:0]              col_ext;

	assign col_ext = {1'b0, col};

	// The stored pair belongs to this cell's column; the readout pair walks
	// towards cell zero so that cell zero shows the column in hand; for column zero the stored pair of cell zero is used.
	always_ff @(posedge clk) begin
		if (bus.push) begin
			if (col_ext == SELF) begin
				st_pix_q <= bus.pixel;
			end
			if (bus.left_wr && col_ext == NEIGH) begin
				st_flag_q <= bus.left_flag;
			end else if (bus.end_wr && col_ext == SELF) begin
				st_flag_q <= bus.flag;
			end
			if (bus.reload) begin
				rd_pix_q  <= nxt_st_pix;
				rd_flag_q <= nxt_st_flag;
			end else begin
				rd_pix_q  <= nxt_rd_pix;
				rd_flag_q <= nxt_rd_flag;
			end
		end
	end

	assign st_pix  = st_pix_q;
	assign st_flag = st_flag_q;
	assign rd_pix  = rd_pix_q;
	assign rd_flag = rd_flag_q;

endmodule

// File: src/contrast_pixel_counter.sv
// Counts the pixels of a grey frame whose value differs from at least one
// of its four neighbours by more than the threshold. Pixels arrive in raster
// order and one is accepted in every clock cycle; the whole decision for a
// pixel is one compare-and-count stage fed by a row of per-column cells that
// hold the previous row and pass it towards cell zero beat by beat. The
// count of a frame appears on the output in the cycle after its final pixel is
// accepted, and only that final pixel is held back while an earlier count still
// waits to be taken. Frame size and threshold are written through the register
// port and apply from the next pixel.
module contrast_pixel_counter #(
	parameter int MAX_WIDTH = 512,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cpc_pkg::ADDR_W-1:0]      paddr,
	input  logic [cpc_pkg::DATA_W-1:0]      pwdata,
	output logic [cpc_pkg::DATA_W-1:0]      prdata,
	output logic                            pready,
	input  logic                            pixel_valid,
	output logic                            pixel_stall,
	input  logic [cpc_pkg::PIXEL_W-1:0]     pixel,
	output logic                            count_valid,
	input  logic                            count_stall,
	output logic [cpc_pkg::COUNT_W-1:0]     contrast_count
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WCMP_W = (COL_W + 1 > cpc_pkg::WIDTH_REG_W) ?
		COL_W + 1 : cpc_pkg::WIDTH_REG_W;
	localparam int HCMP_W = (ROW_W + 1 > cpc_pkg::HEIGHT_REG_W) ?
		ROW_W + 1 : cpc_pkg::HEIGHT_REG_W;

	logic [cpc_pkg::WIDTH_REG_W-1:0]  width_q;
	logic [cpc_pkg::HEIGHT_REG_W-1:0] height_q;
	logic [cpc_pkg::THRESH_REG_W-1:0] thresh_q;

	logic [COL_W-1:0]            column_q;
	logic [ROW_W-1:0]            row_q;
	logic [cpc_pkg::PIXEL_W-1:0] left_pix_q;
	logic                        left_flag_q;
	logic [cpc_pkg::COUNT_W-1:0] running_q;
	logic                        count_valid_q;
	logic [cpc_pkg::COUNT_W-1:0] count_q;

	logic [COL_W-1:0]            col_last;
	logic [ROW_W-1:0]            row_last;
	logic                        last_col;
	logic                        last_row;
	logic                        frame_end;
	logic                        accept;
	logic                        cfg_wr;
	logic [cpc_pkg::REG_IDX_W-1:0] cfg_idx;

	logic [cpc_pkg::PIXEL_W-1:0] above_pix;
	logic                        above_flag;
	logic [cpc_pkg::PIXEL_W-1:0] left_diff;
	logic [cpc_pkg::PIXEL_W-1:0] up_diff;
	logic                        left_hit;
	logic                        up_hit;
	logic                        left_final;
	logic                        up_final;
	logic                        flag;
	logic [1:0]                  inc;
	logic [cpc_pkg::COUNT_W-1:0] sum;

	cpc_pkg::cell_bus_t bus;

	logic [cpc_pkg::PIXEL_W-1:0] st_pix  [MAX_WIDTH];
	logic                        st_flag [MAX_WIDTH];
	logic [cpc_pkg::PIXEL_W-1:0] rd_pix  [MAX_WIDTH];
	logic                        rd_flag [MAX_WIDTH];

	assign pready  = 1'b1;
	assign cfg_idx = paddr[cpc_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= cpc_pkg::WIDTH_RESET;
			height_q <= cpc_pkg::HEIGHT_RESET;
			thresh_q <= cpc_pkg::THRESH_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				cpc_pkg::REG_IMAGE_WIDTH: begin
					width_q <= pwdata[cpc_pkg::WIDTH_REG_W-1:0];
				end
				cpc_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= pwdata[cpc_pkg::HEIGHT_REG_W-1:0];
				end
				cpc_pkg::REG_THRESHOLD: begin
					thresh_q <= pwdata[cpc_pkg::THRESH_REG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			cpc_pkg::REG_IMAGE_WIDTH:  prdata = cpc_pkg::DATA_W'(width_q);
			cpc_pkg::REG_IMAGE_HEIGHT: prdata = cpc_pkg::DATA_W'(height_q);
			cpc_pkg::REG_THRESHOLD:    prdata = cpc_pkg::DATA_W'(thresh_q);
			default:                   prdata = '0;
		endcase
	end

	always_comb begin
		if (width_q == '0) begin
			col_last = '0;
		end else if (WCMP_W'(width_q) > WCMP_W'(MAX_WIDTH)) begin
			col_last = COL_W'(MAX_WIDTH - 1);
		end else begin
			col_last = COL_W'(width_q - 1'b1);
		end
		if (height_q == '0) begin
			row_last = '0;
		end else if (HCMP_W'(height_q) > HCMP_W'(MAX_HEIGHT)) begin
			row_last = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			row_last = ROW_W'(height_q - 1'b1);
		end
	end

	assign last_col  = column_q >= col_last;
	assign last_row  = row_q >= row_last;
	assign frame_end = last_col & last_row;

	assign pixel_stall = count_valid_q & count_stall & frame_end;
	assign accept      = pixel_valid & ~pixel_stall;

	assign above_pix  = (column_q == '0) ? st_pix[0] : rd_pix[0];
	assign above_flag = (column_q == '0) ? st_flag[0] : rd_flag[0];

	assign left_diff = (left_pix_q > pixel) ? left_pix_q - pixel : pixel - left_pix_q;
	assign up_diff   = (above_pix > pixel) ? above_pix - pixel : pixel - above_pix;

	assign left_hit   = (column_q != '0) & (left_diff > thresh_q);
	assign up_hit     = (row_q != '0) & (up_diff > thresh_q);
	assign left_final = left_flag_q | left_hit;
	assign up_final   = above_flag | up_hit;
	assign flag       = left_hit | up_hit;

	// A pixel is settled when its last partner arrives: the one above when
	// the pixel below comes, a last-row pixel when its right one comes or
	// when it ends the frame.
	assign inc = {1'b0, (column_q != '0) & last_row & left_final}
		+ {1'b0, (row_q != '0) & up_final}
		+ {1'b0, frame_end & flag};
	assign sum = running_q + cpc_pkg::COUNT_W'(inc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			row_q       <= '0;
			left_pix_q  <= '0;
			left_flag_q <= 1'b0;
			running_q   <= '0;
		end else if (accept) begin
			left_pix_q  <= pixel;
			left_flag_q <= flag;
			if (last_col) begin
				column_q <= '0;
				row_q    <= last_row ? '0 : row_q + 1'b1;
			end else begin
				column_q <= column_q + 1'b1;
			end
			running_q <= frame_end ? '0 : sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_valid_q <= 1'b0;
		end else if (accept && frame_end) begin
			count_valid_q <= 1'b1;
		end else if (!count_stall) begin
			count_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && frame_end) begin
			count_q <= sum;
		end
	end

	assign count_valid    = count_valid_q;
	assign contrast_count = count_q;

	assign bus.push      = accept;
	assign bus.reload    = column_q == '0;
	assign bus.left_wr   = (column_q != '0) & ~last_row;
	assign bus.end_wr    = last_col & ~last_row;
	assign bus.left_flag = left_final;
	assign bus.flag      = flag;
	assign bus.pixel     = pixel;

	for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
		logic [cpc_pkg::PIXEL_W-1:0] nxt_st_pix;
		logic                        nxt_st_flag;
		logic [cpc_pkg::PIXEL_W-1:0] nxt_rd_pix;
		logic                        nxt_rd_flag;

		if (i == MAX_WIDTH - 1) begin : g_end
			assign nxt_st_pix  = '0;
			assign nxt_st_flag = 1'b0;
			assign nxt_rd_pix  = '0;
			assign nxt_rd_flag = 1'b0;
		end else begin : g_mid
			assign nxt_st_pix  = st_pix[i+1];
			assign nxt_st_flag = st_flag[i+1];
			assign nxt_rd_pix  = rd_pix[i+1];
			assign nxt_rd_flag = rd_flag[i+1];
		end

		cpc_cell #(
			.COL_W (COL_W),
			.INDEX (i)
		) u_cell (
			.clk         (clk),
			.col         (column_q),
			.bus         (bus),
			.nxt_st_pix  (nxt_st_pix),
			.nxt_st_flag (nxt_st_flag),
			.nxt_rd_pix  (nxt_rd_pix),
			.nxt_rd_flag (nxt_rd_flag),
			.st_pix      (st_pix[i]),
			.st_flag     (st_flag[i]),
			.rd_pix      (rd_pix[i]),
			.rd_flag     (rd_flag[i])
		);
	end

endmodule

// File: src/cpc_checker.sv
module cpc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [cpc_pkg::ADDR_W-1:0]   paddr,
	input logic [cpc_pkg::DATA_W-1:0]   pwdata,
	input logic [cpc_pkg::DATA_W-1:0]   prdata,
	input logic                         pready,
	input logic                         pixel_valid,
	input logic                         pixel_stall,
	input logic                         count_valid,
	input logic                         count_stall,
	input logic [cpc_pkg::COUNT_W-1:0]  contrast_count
);

	// A count held back by the receiver stays on the port unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_valid && count_stall |=> count_valid && $stable(contrast_count))
		else $error("stalled count beat changed");

	// A fresh count only ever follows an accepted pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(count_valid) |-> $past(pixel_valid && !pixel_stall))
		else $error("count beat without a pixel beat before it");

	// Pixels are held back only while a finished count waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> count_valid && count_stall)
		else $error("pixel stall with no count waiting");

	// A threshold just written reads back at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(psel && penable && pwrite && pready
			&& paddr[cpc_pkg::ADDR_W-1:2] == cpc_pkg::REG_THRESHOLD)
		&& psel && !pwrite && paddr[cpc_pkg::ADDR_W-1:2] == cpc_pkg::REG_THRESHOLD
		|-> prdata[cpc_pkg::THRESH_REG_W-1:0] == $past(pwdata[cpc_pkg::THRESH_REG_W-1:0]))
		else $error("threshold read-back mismatch");

endmodule

bind contrast_pixel_counter cpc_checker u_cpc_checker (.*);
